[rtl/rsi_pkg.sv]
// ----------------------------------------------------------------------------
// rsi_pkg
// shared widths, types and constants of the ray and sphere intersection unit
// ----------------------------------------------------------------------------
`default_nettype none

package rsi_pkg;

    // fixed-point format of every coordinate, time and point
    localparam int FRAC_BITS   = 16;
    localparam int COORD_WIDTH = 32;
    localparam int RAD_WIDTH   = COORD_WIDTH - 1;

    // magnitude of b, a, c and of the root
    localparam int MAG_WIDTH  = 2 * COORD_WIDTH;
    localparam int HALF_WIDTH = COORD_WIDTH;
    // signed sums b, c and the numerators -b -+ s
    localparam int SUM_WIDTH  = 2 * COORD_WIDTH + 2;
    // squares b^2, a*|c| and a nonnegative discriminant
    localparam int SQ_WIDTH   = 4 * COORD_WIDTH;
    localparam int DISC_WIDTH = 4 * COORD_WIDTH + 2;
    // scaled numerator magnitude and divider remainder
    localparam int NUM_WIDTH  = 2 * COORD_WIDTH + 1 + FRAC_BITS;
    localparam int REM_WIDTH  = 2 * COORD_WIDTH + 1;

    // queue between front and back, depth must be a power of two
    localparam int QUEUE_DEPTH = 4;
    localparam int QPTR_WIDTH  = $clog2(QUEUE_DEPTH);

    typedef logic signed [COORD_WIDTH-1:0] t_coord;
    typedef logic [RAD_WIDTH-1:0]          t_rad;
    typedef logic [1:0]                    t_count;

    localparam t_count CNT_MISS    = 2'd0;
    localparam t_count CNT_TANGENT = 2'd1;
    localparam t_count CNT_CROSS   = 2'd2;

    localparam t_coord COORD_MAX  = {1'b0, {(COORD_WIDTH-1){1'b1}}};
    localparam t_coord COORD_MIN  = {1'b1, {(COORD_WIDTH-1){1'b0}}};
    localparam t_coord NONE_VALUE = COORD_WIDTH'(-(longint'(999) <<< FRAC_BITS));
    localparam t_rad   RAD_RESET  = RAD_WIDTH'(longint'(6371) << FRAC_BITS);

    // index 0 is x, 1 is y, 2 is z
    typedef struct packed {
        t_coord [2:0] org;
        t_coord [2:0] vel;
    } t_ray;

    typedef struct packed {
        t_ray                         ray;
        logic [MAG_WIDTH-1:0]         a;
        logic signed [SUM_WIDTH-1:0]  nb;
        t_count                       cnt;
    } t_ctx;

    typedef struct packed {
        t_ctx                 ctx;
        logic [SQ_WIDTH-1:0]  disc;
    } t_job;

    // index 0 is the near hit, 1 the far hit
    typedef struct packed {
        t_count             cnt;
        t_coord [1:0]       tim;
        t_coord [1:0][2:0]  pt;
    } t_hit;

endpackage

`default_nettype wire

[rtl/rsi_ray_if.sv]
// ----------------------------------------------------------------------------
// rsi_ray_if
// ray channel: origin and velocity with valid and ready
// ----------------------------------------------------------------------------
`default_nettype none

interface rsi_ray_if import rsi_pkg::*; ();
    logic   valid;
    logic   ready;
    t_coord origin_x;
    t_coord origin_y;
    t_coord origin_z;
    t_coord velocity_x;
    t_coord velocity_y;
    t_coord velocity_z;

    modport source (output valid, output origin_x, output origin_y, output origin_z,
                    output velocity_x, output velocity_y, output velocity_z, input ready);
    modport sink (input valid, input origin_x, input origin_y, input origin_z,
                  input velocity_x, input velocity_y, input velocity_z, output ready);
endinterface

`default_nettype wire

[rtl/rsi_hit_if.sv]
// ----------------------------------------------------------------------------
// rsi_hit_if
// result channel: hit count, times and points with valid and ready
// ----------------------------------------------------------------------------
`default_nettype none

interface rsi_hit_if import rsi_pkg::*; ();
    logic   valid;
    logic   ready;
    t_count hit_count;
    t_coord near_time;
    t_coord near_x;
    t_coord near_y;
    t_coord near_z;
    t_coord far_time;
    t_coord far_x;
    t_coord far_y;
    t_coord far_z;

    modport source (output valid, output hit_count, output near_time, output near_x,
                    output near_y, output near_z, output far_time, output far_x,
                    output far_y, output far_z, input ready);
    modport sink (input valid, input hit_count, input near_time, input near_x,
                  input near_y, input near_z, input far_time, input far_x,
                  input far_y, input far_z, output ready);
endinterface

`default_nettype wire

[rtl/rsi_cfg_if.sv]
// ----------------------------------------------------------------------------
// rsi_cfg_if
// configuration write channel for the sphere radius
// ----------------------------------------------------------------------------
`default_nettype none

interface rsi_cfg_if import rsi_pkg::*; ();
    logic valid;
    logic ready;
    t_rad sphere_radius;

    modport source (output valid, output sphere_radius, input ready);
    modport sink (input valid, input sphere_radius, output ready);
endinterface

`default_nettype wire

[rtl/rsi_front.sv]
// ----------------------------------------------------------------------------
// rsi_front
// dot products, discriminant and hit classification, seven stages
// ----------------------------------------------------------------------------
`default_nettype none

module rsi_front import rsi_pkg::*; (
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    input  wire logic i_valid,
    output logic      o_ready,
    input  wire t_ray i_ray,
    input  wire t_rad i_radius,
    output logic      o_valid,
    input  wire logic i_ready,
    output t_job      o_job
);

    localparam int STAGES = 7;

    logic [STAGES-1:0] r_vld;
    logic              adv;

    // stage 1: products
    t_ray                          r1_ray;
    logic signed [MAG_WIDTH-1:0]   r1_pb [3];
    logic signed [MAG_WIDTH-1:0]   r1_pa [3];
    logic signed [MAG_WIDTH-1:0]   r1_pc [3];
    logic [MAG_WIDTH-1:0]          r1_rr;
    // stage 2: sums
    t_ray                          r2_ray;
    logic signed [SUM_WIDTH-1:0]   r2_b;
    logic signed [SUM_WIDTH-1:0]   r2_c;
    logic [MAG_WIDTH-1:0]          r2_a;
    // stage 3: magnitudes
    t_ctx                          r3_ctx;
    logic                          r3_az;
    logic [MAG_WIDTH-1:0]          r3_mb;
    logic [MAG_WIDTH-1:0]          r3_mc;
    logic                          r3_cneg;
    // stage 4: partial products
    t_ctx                          r4_ctx;
    logic                          r4_az;
    logic                          r4_cneg;
    logic [MAG_WIDTH-1:0]          r4_bb_ll, r4_bb_lh, r4_bb_hh;
    logic [MAG_WIDTH-1:0]          r4_ac_ll, r4_ac_lh, r4_ac_hl, r4_ac_hh;
    // stage 5: squares
    t_ctx                          r5_ctx;
    logic                          r5_az;
    logic                          r5_cneg;
    logic [SQ_WIDTH-1:0]           r5_b2;
    logic [SQ_WIDTH-1:0]           r5_ac;
    // stage 6: discriminant
    t_ctx                          r6_ctx;
    logic                          r6_az;
    logic signed [DISC_WIDTH-1:0]  r6_disc;
    // stage 7: classified job
    t_job                          r7_job;

    t_count                        n_cnt;
    logic signed [SUM_WIDTH-1:0]   n_nb;

    assign adv     = !r_vld[STAGES-1] || i_ready;
    assign o_ready = adv;
    assign o_valid = r_vld[STAGES-1];
    assign o_job   = r7_job;
    assign n_nb    = -r2_b;

    always_comb begin
        if (r6_az || r6_disc[DISC_WIDTH-1]) begin
            n_cnt = CNT_MISS;
        end else if (r6_disc == '0) begin
            n_cnt = CNT_TANGENT;
        end else begin
            n_cnt = CNT_CROSS;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (adv) begin
            r_vld <= {r_vld[STAGES-2:0], i_valid};
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r1_ray <= i_ray;
            for (int i = 0; i < 3; i++) begin
                r1_pb[i] <= $signed(i_ray.vel[i]) * $signed(i_ray.org[i]);
                r1_pa[i] <= $signed(i_ray.vel[i]) * $signed(i_ray.vel[i]);
                r1_pc[i] <= $signed(i_ray.org[i]) * $signed(i_ray.org[i]);
            end
            r1_rr <= MAG_WIDTH'(i_radius) * MAG_WIDTH'(i_radius);

            r2_ray <= r1_ray;
            r2_b   <= SUM_WIDTH'(r1_pb[0]) + SUM_WIDTH'(r1_pb[1]) + SUM_WIDTH'(r1_pb[2]);
            r2_a   <= r1_pa[0] + r1_pa[1] + r1_pa[2];
            r2_c   <= SUM_WIDTH'(r1_pc[0]) + SUM_WIDTH'(r1_pc[1]) + SUM_WIDTH'(r1_pc[2])
                      - $signed(SUM_WIDTH'(r1_rr));

            r3_ctx.ray <= r2_ray;
            r3_ctx.a   <= r2_a;
            r3_ctx.nb  <= n_nb;
            r3_ctx.cnt <= CNT_MISS;
            r3_az      <= (r2_a == '0);
            r3_mb      <= MAG_WIDTH'(r2_b[SUM_WIDTH-1] ? -r2_b : r2_b);
            r3_mc      <= MAG_WIDTH'(r2_c[SUM_WIDTH-1] ? -r2_c : r2_c);
            r3_cneg    <= r2_c[SUM_WIDTH-1];

            r4_ctx   <= r3_ctx;
            r4_az    <= r3_az;
            r4_cneg  <= r3_cneg;
            r4_bb_ll <= r3_mb[HALF_WIDTH-1:0] * r3_mb[HALF_WIDTH-1:0];
            r4_bb_lh <= r3_mb[HALF_WIDTH-1:0] * r3_mb[MAG_WIDTH-1:HALF_WIDTH];
            r4_bb_hh <= r3_mb[MAG_WIDTH-1:HALF_WIDTH] * r3_mb[MAG_WIDTH-1:HALF_WIDTH];
            r4_ac_ll <= r3_ctx.a[HALF_WIDTH-1:0] * r3_mc[HALF_WIDTH-1:0];
            r4_ac_lh <= r3_ctx.a[HALF_WIDTH-1:0] * r3_mc[MAG_WIDTH-1:HALF_WIDTH];
            r4_ac_hl <= r3_ctx.a[MAG_WIDTH-1:HALF_WIDTH] * r3_mc[HALF_WIDTH-1:0];
            r4_ac_hh <= r3_ctx.a[MAG_WIDTH-1:HALF_WIDTH] * r3_mc[MAG_WIDTH-1:HALF_WIDTH];

            r5_ctx  <= r4_ctx;
            r5_az   <= r4_az;
            r5_cneg <= r4_cneg;
            // cross term of a square counts twice
            r5_b2   <= {r4_bb_hh, r4_bb_ll} + (SQ_WIDTH'(r4_bb_lh) << (HALF_WIDTH + 1));
            r5_ac   <= {r4_ac_hh, r4_ac_ll} + (SQ_WIDTH'(r4_ac_lh) << HALF_WIDTH)
                       + (SQ_WIDTH'(r4_ac_hl) << HALF_WIDTH);

            r6_ctx  <= r5_ctx;
            r6_az   <= r5_az;
            r6_disc <= r5_cneg ? $signed(DISC_WIDTH'(r5_b2)) + $signed(DISC_WIDTH'(r5_ac))
                               : $signed(DISC_WIDTH'(r5_b2)) - $signed(DISC_WIDTH'(r5_ac));

            r7_job.ctx.ray <= r6_ctx.ray;
            r7_job.ctx.a   <= r6_ctx.a;
            r7_job.ctx.nb  <= r6_ctx.nb;
            r7_job.ctx.cnt <= n_cnt;
            r7_job.disc    <= r6_disc[SQ_WIDTH-1:0];
        end
    end

endmodule

`default_nettype wire

[rtl/rsi_queue.sv]
// ----------------------------------------------------------------------------
// rsi_queue
// short first-in first-out queue of classified jobs
// ----------------------------------------------------------------------------
`default_nettype none

module rsi_queue import rsi_pkg::*; (
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    input  wire logic i_valid,
    output logic      o_ready,
    input  wire t_job i_job,
    output logic      o_valid,
    input  wire logic i_ready,
    output t_job      o_job
);

    t_job                  r_mem [QUEUE_DEPTH];
    logic [QPTR_WIDTH-1:0] r_wr;
    logic [QPTR_WIDTH-1:0] r_rd;
    logic [QPTR_WIDTH:0]   r_cnt;
    logic                  push;
    logic                  pop;

    assign o_ready = (r_cnt != (QPTR_WIDTH+1)'(QUEUE_DEPTH));
    assign o_valid = (r_cnt != '0);
    assign o_job   = r_mem[r_rd];
    assign push    = i_valid && o_ready;
    assign pop     = o_valid && i_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            if (push) begin
                r_wr <= r_wr + 1'b1;
            end
            if (pop) begin
                r_rd <= r_rd + 1'b1;
            end
            if (push && !pop) begin
                r_cnt <= r_cnt + 1'b1;
            end else if (pop && !push) begin
                r_cnt <= r_cnt - 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (push) begin
            r_mem[r_wr] <= i_job;
        end
    end

endmodule

`default_nettype wire

[rtl/rsi_back.sv]
// ----------------------------------------------------------------------------
// rsi_back
// square root, two dividers and hit points, fully pipelined
// ----------------------------------------------------------------------------
`default_nettype none

module rsi_back import rsi_pkg::*; (
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    input  wire logic i_valid,
    output logic      o_ready,
    input  wire t_job i_job,
    output logic      o_valid,
    input  wire logic i_ready,
    output t_hit      o_hit
);

    localparam int SQ_STAGES  = MAG_WIDTH;
    localparam int DIV_STAGES = NUM_WIDTH;
    localparam int STAGES     = SQ_STAGES + 2 + DIV_STAGES + 3;
    localparam int PT_WIDTH   = 2 * COORD_WIDTH + 1;
    localparam logic [NUM_WIDTH:0] POS_LIM = ((NUM_WIDTH+1)'(1) << (COORD_WIDTH-1)) - 1'b1;
    localparam logic [NUM_WIDTH:0] NEG_LIM = (NUM_WIDTH+1)'(1) << (COORD_WIDTH-1);

    logic [STAGES-1:0] r_vld;
    logic              adv;

    // square root stages, one root bit each
    t_ctx                  r_sq_ctx  [SQ_STAGES];
    logic [SQ_WIDTH-1:0]   r_sq_rem  [SQ_STAGES];
    logic [MAG_WIDTH-1:0]  r_sq_root [SQ_STAGES];
    t_ctx                  sq_ctx_in [SQ_STAGES];
    logic [SQ_WIDTH-1:0]   sq_rem_in [SQ_STAGES];
    logic [MAG_WIDTH-1:0]  sq_root_in [SQ_STAGES];
    logic [SQ_WIDTH-1:0]   sq_trial  [SQ_STAGES];
    logic [SQ_WIDTH-1:0]   n_sq_rem  [SQ_STAGES];
    logic [MAG_WIDTH-1:0]  n_sq_root [SQ_STAGES];

    // numerators
    t_ctx                         r_n1_ctx;
    logic signed [SUM_WIDTH-1:0]  r_n1_sum [2];
    t_ctx                         r_n2_ctx;
    logic [NUM_WIDTH-1:0]         r_n2_mag [2];
    logic                         r_n2_neg [2];
    logic signed [SUM_WIDTH-1:0]  n_abs    [2];

    // divider stages, one quotient bit each
    t_ctx                  r_dv_ctx [DIV_STAGES];
    logic [NUM_WIDTH-1:0]  r_dv_q   [DIV_STAGES][2];
    logic [REM_WIDTH-1:0]  r_dv_r   [DIV_STAGES][2];
    logic                  r_dv_neg [DIV_STAGES][2];
    t_ctx                  dv_ctx_in [DIV_STAGES];
    logic [NUM_WIDTH-1:0]  dv_q_in  [DIV_STAGES][2];
    logic [REM_WIDTH-1:0]  dv_r_in  [DIV_STAGES][2];
    logic                  dv_neg_in [DIV_STAGES][2];
    logic [REM_WIDTH-1:0]  dv_trial [DIV_STAGES][2];
    logic                  dv_ge    [DIV_STAGES][2];
    logic [NUM_WIDTH-1:0]  n_dv_q   [DIV_STAGES][2];
    logic [REM_WIDTH-1:0]  n_dv_r   [DIV_STAGES][2];

    // times, products and output
    t_ctx                          r_t1_ctx;
    t_coord                        r_t1_t [2];
    logic [NUM_WIDTH:0]            n_qa   [2];
    t_coord                        n_t    [2];
    t_ctx                          r_t2_ctx;
    t_coord                        r_t2_t [2];
    logic signed [MAG_WIDTH-1:0]   r_t2_prod [2][3];
    logic signed [MAG_WIDTH-1:0]   n_sh   [2][3];
    logic signed [PT_WIDTH-1:0]    n_pt   [2][3];
    t_hit                          n_hit;
    t_hit                          r_out;

    function automatic t_coord sat_coord(input logic signed [PT_WIDTH-1:0] v);
        t_coord res;
        if (v > PT_WIDTH'(COORD_MAX)) begin
            res = COORD_MAX;
        end else if (v < PT_WIDTH'(COORD_MIN)) begin
            res = COORD_MIN;
        end else begin
            res = v[COORD_WIDTH-1:0];
        end
        return res;
    endfunction

    assign adv     = !r_vld[STAGES-1] || i_ready;
    assign o_ready = adv;
    assign o_valid = r_vld[STAGES-1];
    assign o_hit   = r_out;

    // root bit i = SQ_STAGES-1-k; rem holds disc - root^2
    always_comb begin
        for (int k = 0; k < SQ_STAGES; k++) begin
            if (k == 0) begin
                sq_ctx_in[k]  = i_job.ctx;
                sq_rem_in[k]  = i_job.disc;
                sq_root_in[k] = '0;
            end else begin
                sq_ctx_in[k]  = r_sq_ctx[k-1];
                sq_rem_in[k]  = r_sq_rem[k-1];
                sq_root_in[k] = r_sq_root[k-1];
            end
            sq_trial[k] = (SQ_WIDTH'(sq_root_in[k]) << (SQ_STAGES - k))
                          + (SQ_WIDTH'(1) << (2 * (SQ_STAGES - 1 - k)));
            if (sq_rem_in[k] >= sq_trial[k]) begin
                n_sq_rem[k]  = sq_rem_in[k] - sq_trial[k];
                n_sq_root[k] = sq_root_in[k] | (MAG_WIDTH'(1) << (SQ_STAGES - 1 - k));
            end else begin
                n_sq_rem[k]  = sq_rem_in[k];
                n_sq_root[k] = sq_root_in[k];
            end
        end
    end

    always_comb begin
        for (int j = 0; j < 2; j++) begin
            n_abs[j] = r_n1_sum[j][SUM_WIDTH-1] ? -r_n1_sum[j] : r_n1_sum[j];
        end
    end

    // restoring division of the numerator magnitude by a
    always_comb begin
        for (int k = 0; k < DIV_STAGES; k++) begin
            if (k == 0) begin
                dv_ctx_in[k] = r_n2_ctx;
            end else begin
                dv_ctx_in[k] = r_dv_ctx[k-1];
            end
            for (int j = 0; j < 2; j++) begin
                if (k == 0) begin
                    dv_q_in[k][j]   = r_n2_mag[j];
                    dv_r_in[k][j]   = '0;
                    dv_neg_in[k][j] = r_n2_neg[j];
                end else begin
                    dv_q_in[k][j]   = r_dv_q[k-1][j];
                    dv_r_in[k][j]   = r_dv_r[k-1][j];
                    dv_neg_in[k][j] = r_dv_neg[k-1][j];
                end
                dv_trial[k][j] = {dv_r_in[k][j][REM_WIDTH-2:0], dv_q_in[k][j][NUM_WIDTH-1]};
                dv_ge[k][j]    = dv_trial[k][j] >= REM_WIDTH'(dv_ctx_in[k].a);
                n_dv_r[k][j]   = dv_ge[k][j] ? dv_trial[k][j] - REM_WIDTH'(dv_ctx_in[k].a)
                                             : dv_trial[k][j];
                n_dv_q[k][j]   = {dv_q_in[k][j][NUM_WIDTH-2:0], dv_ge[k][j]};
            end
        end
    end

    // floor toward minus infinity, then saturate the time
    always_comb begin
        for (int j = 0; j < 2; j++) begin
            n_qa[j] = {1'b0, r_dv_q[DIV_STAGES-1][j]}
                      + (NUM_WIDTH+1)'(r_dv_neg[DIV_STAGES-1][j]
                                       && (r_dv_r[DIV_STAGES-1][j] != '0));
            if (r_dv_neg[DIV_STAGES-1][j]) begin
                n_t[j] = (n_qa[j] > NEG_LIM) ? COORD_MIN : COORD_WIDTH'(-n_qa[j]);
            end else begin
                n_t[j] = (n_qa[j] > POS_LIM) ? COORD_MAX : COORD_WIDTH'(n_qa[j]);
            end
        end
    end

    always_comb begin
        for (int j = 0; j < 2; j++) begin
            for (int i = 0; i < 3; i++) begin
                n_sh[j][i] = r_t2_prod[j][i] >>> FRAC_BITS;
                n_pt[j][i] = PT_WIDTH'($signed(r_t2_ctx.ray.org[i])) + PT_WIDTH'(n_sh[j][i]);
            end
        end
        n_hit.cnt = r_t2_ctx.cnt;
        for (int j = 0; j < 2; j++) begin
            if ((j == 0 && r_t2_ctx.cnt != CNT_MISS) || r_t2_ctx.cnt == CNT_CROSS) begin
                n_hit.tim[j] = r_t2_t[j];
                for (int i = 0; i < 3; i++) begin
                    n_hit.pt[j][i] = sat_coord(n_pt[j][i]);
                end
            end else begin
                n_hit.tim[j] = NONE_VALUE;
                for (int i = 0; i < 3; i++) begin
                    n_hit.pt[j][i] = NONE_VALUE;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (adv) begin
            r_vld <= {r_vld[STAGES-2:0], i_valid};
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv) begin
            for (int k = 0; k < SQ_STAGES; k++) begin
                r_sq_ctx[k]  <= sq_ctx_in[k];
                r_sq_rem[k]  <= n_sq_rem[k];
                r_sq_root[k] <= n_sq_root[k];
            end

            r_n1_ctx    <= r_sq_ctx[SQ_STAGES-1];
            r_n1_sum[0] <= r_sq_ctx[SQ_STAGES-1].nb
                           - $signed(SUM_WIDTH'(r_sq_root[SQ_STAGES-1]));
            r_n1_sum[1] <= r_sq_ctx[SQ_STAGES-1].nb
                           + $signed(SUM_WIDTH'(r_sq_root[SQ_STAGES-1]));

            r_n2_ctx <= r_n1_ctx;
            for (int j = 0; j < 2; j++) begin
                r_n2_neg[j] <= r_n1_sum[j][SUM_WIDTH-1];
                r_n2_mag[j] <= {n_abs[j][NUM_WIDTH-FRAC_BITS-1:0], {FRAC_BITS{1'b0}}};
            end

            for (int k = 0; k < DIV_STAGES; k++) begin
                r_dv_ctx[k] <= dv_ctx_in[k];
                for (int j = 0; j < 2; j++) begin
                    r_dv_q[k][j]   <= n_dv_q[k][j];
                    r_dv_r[k][j]   <= n_dv_r[k][j];
                    r_dv_neg[k][j] <= dv_neg_in[k][j];
                end
            end

            r_t1_ctx <= r_dv_ctx[DIV_STAGES-1];
            r_t2_ctx <= r_t1_ctx;
            for (int j = 0; j < 2; j++) begin
                r_t1_t[j] <= n_t[j];
                r_t2_t[j] <= r_t1_t[j];
                for (int i = 0; i < 3; i++) begin
                    r_t2_prod[j][i] <= $signed(r_t1_ctx.ray.vel[i]) * r_t1_t[j];
                end
            end

            r_out <= n_hit;
        end
    end

endmodule

`default_nettype wire

[rtl/ray_sphere_intersection_unit.sv]
// ----------------------------------------------------------------------------
// ray_sphere_intersection_unit
// intersects rays with a sphere about the origin; unless o_hit stalls, one ray per clock
// ----------------------------------------------------------------------------
//
//  channel   dir   beat content
//  --------  ----  ------------------------------------------------------
//  i_ray     in    origin x/y/z and velocity x/y/z, signed Q16.16
//  o_hit     out   hit count, near and far time and point, signed Q16.16
//  i_cfg     in    sphere radius, unsigned Q15.16, always ready
//
//  one ray per clock sustained while o_hit is not stalled; from input to result
//  a ray passes 7 front stages, one queue slot, 64 root stages (one bit each),
//  81 divider stages (one quotient bit each) and 5 further stages
//  i_rst_n is synchronous; it empties the pipeline and sets the radius to 6371.0
//  a stalled o_hit freezes the back; the front keeps going until its
//  four-entry queue fills, then i_ray.ready drops
//
`default_nettype none

module ray_sphere_intersection_unit import rsi_pkg::*; (
    input  wire logic  i_clk,
    input  wire logic  i_rst_n,
    rsi_ray_if.sink    i_ray,
    rsi_hit_if.source  o_hit,
    rsi_cfg_if.sink    i_cfg
);

    t_rad r_radius;

    // front to queue
    t_ray ray_in;
    logic fq_valid;
    logic fq_ready;
    t_job fq_job;
    logic front_ready;

    // queue to back
    logic qb_valid;
    logic qb_ready;
    t_job qb_job;

    // back to result channel
    t_hit hit;
    logic hit_valid;

    // radius register; the user must write it only while the unit is idle, the block does not enforce it
    assign i_cfg.ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_radius <= RAD_RESET;
        end else if (i_cfg.valid) begin
            r_radius <= i_cfg.sphere_radius;
        end
    end

    assign ray_in.org[0] = i_ray.origin_x;
    assign ray_in.org[1] = i_ray.origin_y;
    assign ray_in.org[2] = i_ray.origin_z;
    assign ray_in.vel[0] = i_ray.velocity_x;
    assign ray_in.vel[1] = i_ray.velocity_y;
    assign ray_in.vel[2] = i_ray.velocity_z;
    assign i_ray.ready   = front_ready;

    // products, discriminant and classification
    rsi_front u_front (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (i_ray.valid),
        .o_ready  (front_ready),
        .i_ray    (ray_in),
        .i_radius (r_radius),
        .o_valid  (fq_valid),
        .i_ready  (fq_ready),
        .o_job    (fq_job)
    );

    // decouples the front from stalls of the back
    rsi_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (fq_valid),
        .o_ready (fq_ready),
        .i_job   (fq_job),
        .o_valid (qb_valid),
        .i_ready (qb_ready),
        .o_job   (qb_job)
    );

    // root, divisions and hit points
    rsi_back u_back (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (qb_valid),
        .o_ready (qb_ready),
        .i_job   (qb_job),
        .o_valid (hit_valid),
        .i_ready (o_hit.ready),
        .o_hit   (hit)
    );

    assign o_hit.valid     = hit_valid;
    assign o_hit.hit_count = hit.cnt;
    assign o_hit.near_time = hit.tim[0];
    assign o_hit.near_x    = hit.pt[0][0];
    assign o_hit.near_y    = hit.pt[0][1];
    assign o_hit.near_z    = hit.pt[0][2];
    assign o_hit.far_time  = hit.tim[1];
    assign o_hit.far_x     = hit.pt[1][0];
    assign o_hit.far_y     = hit.pt[1][1];
    assign o_hit.far_z     = hit.pt[1][2];

endmodule

`default_nettype wire

[tb/sv/tb.sv]
// ----------------------------------------------------------------------------
// tb
// ray and sphere intersection unit: directed and random rays against an
// in-bench fixed-point predictor, with random idling on both channels
// ----------------------------------------------------------------------------
`default_nettype none

module tb;
    import rsi_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    // drain wait covers the full pipeline depth with margin
    localparam int DRAIN_CYCLES = 400;
    localparam int STALL_LIMIT  = 5000;

    typedef struct {
        t_count cnt;
        t_coord tim [2];
        t_coord pt  [2][3];
    } t_expect;

    logic i_clk;
    logic i_rst_n;

    rsi_ray_if ray_ch ();
    rsi_hit_if hit_ch ();
    rsi_cfg_if cfg_ch ();

    ray_sphere_intersection_unit u_dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ray   (ray_ch.sink),
        .o_hit   (hit_ch.source),
        .i_cfg   (cfg_ch.sink)
    );

    // the predictor's own copy of the radius register
    t_rad    radius_q;
    t_expect hit_queue [$];
    int      error_count;
    int      rays_sent;
    int      hits_seen;
    int      hit_tally [3];
    int      idle_cycles;
    int      ready_hold;
    bit      calm_mode;

    // ------------------------------------------------------------------------
    // clock
    // ------------------------------------------------------------------------
    initial i_clk = 1'b0;
    always begin
        #10 i_clk = 1'b1;
        #10 i_clk = 1'b0;
    end

    // ------------------------------------------------------------------------
    // predictor: exact wide arithmetic, 260-bit signed values
    // ------------------------------------------------------------------------
    typedef logic signed [259:0] t_big;

    function automatic t_coord clamp_coord(t_big v);
        if (v > t_big'(COORD_MAX)) return COORD_MAX;
        if (v < t_big'(COORD_MIN)) return COORD_MIN;
        return t_coord'(v);
    endfunction

    // floor division for positive divisor
    function automatic t_big floor_div(t_big n, t_big d);
        t_big q;
        q = n / d;
        if ((n % d != 0) && (n < 0)) q = q - 1;
        return q;
    endfunction

    function automatic t_big int_sqrt(t_big n);
        t_big r;
        t_big cand;
        r = 0;
        for (int i = 127; i >= 0; i--) begin
            cand = r | (t_big'(1) << i);
            if (cand * cand <= n) r = cand;
        end
        return r;
    endfunction

    function automatic void hit_point(t_big num, t_big a, t_big org [3], t_big vel [3],
                                      int slot, inout t_expect e);
        t_coord t;
        t = clamp_coord(floor_div(num, a));
        e.tim[slot] = t;
        for (int k = 0; k < 3; k++)
            e.pt[slot][k] = clamp_coord(org[k] + ((vel[k] * t_big'(t)) >>> FRAC_BITS));
    endfunction

    function automatic t_expect predict_hit(t_coord org_in [3], t_coord vel_in [3]);
        t_expect e;
        t_big org [3];
        t_big vel [3];
        t_big a, b, c, disc, s, rad;
        for (int k = 0; k < 3; k++) begin
            org[k] = t_big'(org_in[k]);
            vel[k] = t_big'(vel_in[k]);
        end
        e.cnt = CNT_MISS;
        for (int j = 0; j < 2; j++) begin
            e.tim[j] = NONE_VALUE;
            for (int k = 0; k < 3; k++) e.pt[j][k] = NONE_VALUE;
        end
        rad  = t_big'({1'b0, radius_q});
        b    = vel[0] * org[0] + vel[1] * org[1] + vel[2] * org[2];
        a    = vel[0] * vel[0] + vel[1] * vel[1] + vel[2] * vel[2];
        c    = org[0] * org[0] + org[1] * org[1] + org[2] * org[2] - rad * rad;
        disc = b * b - a * c;
        if (a == 0 || disc < 0) return e;
        if (disc == 0) begin
            e.cnt = CNT_TANGENT;
            hit_point((-b) <<< FRAC_BITS, a, org, vel, 0, e);
        end else begin
            s = int_sqrt(disc);
            e.cnt = CNT_CROSS;
            hit_point((-b - s) <<< FRAC_BITS, a, org, vel, 0, e);
            hit_point((-b + s) <<< FRAC_BITS, a, org, vel, 1, e);
        end
        return e;
    endfunction

    // ------------------------------------------------------------------------
    // reporting
    // ------------------------------------------------------------------------
    task automatic report_mismatch(string what, int unsigned got, int unsigned want);
        error_count++;
        $display("error: hit %0d %s got %08h want %08h", hits_seen, what, got, want);
    endtask

    // ------------------------------------------------------------------------
    // driving
    // ------------------------------------------------------------------------
    // valid drops only for the length of a burst
    task automatic idle_burst();
        if (!calm_mode && $urandom_range(0, 3) == 0) begin
            ray_ch.valid <= 1'b0;
            repeat ($urandom_range(1, 3)) @(negedge i_clk);
        end
    endtask

    // one ray beat; prediction is made when the beat is accepted
    task automatic send_ray(t_coord ox, t_coord oy, t_coord oz,
                            t_coord vx, t_coord vy, t_coord vz);
        t_coord o [3];
        t_coord v [3];
        o = '{ox, oy, oz};
        v = '{vx, vy, vz};
        idle_burst();
        ray_ch.valid      <= 1'b1;
        ray_ch.origin_x   <= ox;
        ray_ch.origin_y   <= oy;
        ray_ch.origin_z   <= oz;
        ray_ch.velocity_x <= vx;
        ray_ch.velocity_y <= vy;
        ray_ch.velocity_z <= vz;
        do @(posedge i_clk); while (!ray_ch.ready);
        hit_queue.push_back(predict_hit(o, v));
        rays_sent++;
        @(negedge i_clk);
    endtask

    // radius write, only with the pipeline empty
    task automatic write_radius(t_rad r);
        wait_drained();
        cfg_ch.valid         <= 1'b1;
        cfg_ch.sphere_radius <= r;
        do @(posedge i_clk); while (!cfg_ch.ready);
        radius_q = r;
        @(negedge i_clk);
        cfg_ch.valid <= 1'b0;
    endtask

    task automatic wait_drained();
        ray_ch.valid <= 1'b0;
        while (hit_queue.size() != 0) @(negedge i_clk);
        repeat (4) @(negedge i_clk);
    endtask

    function automatic t_coord q16(int whole);
        return t_coord'(whole <<< FRAC_BITS);
    endfunction

    function automatic t_coord rand_coord();
        case ($urandom_range(0, 5))
            0: return t_coord'($urandom);
            1: return COORD_MAX;
            2: return COORD_MIN;
            3: return t_coord'($urandom_range(0, 3)) - 1;
            default: return q16($signed($urandom_range(0, 20000)) - 10000)
                            + t_coord'($urandom_range(0, 65535));
        endcase
    endfunction

    // ------------------------------------------------------------------------
    // result checking and ready idling
    // ------------------------------------------------------------------------
    // ready drops low in random bursts, and each burst ends with ready high again
    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            hit_ch.ready <= 1'b0;
            ready_hold   <= 0;
        end else if (calm_mode) begin
            hit_ch.ready <= 1'b1;
            ready_hold   <= 0;
        end else if (ready_hold > 1) begin
            hit_ch.ready <= 1'b0;
            ready_hold   <= ready_hold - 1;
        end else if (ready_hold == 1) begin
            hit_ch.ready <= 1'b1;
            ready_hold   <= 0;
        end else if ($urandom_range(0, 4) == 0) begin
            hit_ch.ready <= 1'b0;
            ready_hold   <= $urandom_range(1, 3);
        end else begin
            hit_ch.ready <= 1'b1;
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && hit_ch.valid && hit_ch.ready) begin
            t_expect e;
            if (hit_queue.size() == 0) begin
                report_mismatch("unexpected beat", 0, 0);
            end else begin
                e = hit_queue.pop_front();
                if (hit_ch.hit_count != e.cnt)
                    report_mismatch("hit_count", hit_ch.hit_count, e.cnt);
                if (hit_ch.near_time != e.tim[0])
                    report_mismatch("near_time", hit_ch.near_time, e.tim[0]);
                if (hit_ch.near_x != e.pt[0][0])
                    report_mismatch("near_x", hit_ch.near_x, e.pt[0][0]);
                if (hit_ch.near_y != e.pt[0][1])
                    report_mismatch("near_y", hit_ch.near_y, e.pt[0][1]);
                if (hit_ch.near_z != e.pt[0][2])
                    report_mismatch("near_z", hit_ch.near_z, e.pt[0][2]);
                if (hit_ch.far_time != e.tim[1])
                    report_mismatch("far_time", hit_ch.far_time, e.tim[1]);
                if (hit_ch.far_x != e.pt[1][0])
                    report_mismatch("far_x", hit_ch.far_x, e.pt[1][0]);
                if (hit_ch.far_y != e.pt[1][1])
                    report_mismatch("far_y", hit_ch.far_y, e.pt[1][1]);
                if (hit_ch.far_z != e.pt[1][2])
                    report_mismatch("far_z", hit_ch.far_z, e.pt[1][2]);
                if (e.cnt <= CNT_CROSS) hit_tally[e.cnt]++;
            end
            hits_seen++;
        end
    end

    // watchdog: cycles with no beat on any channel while something is pending
    always @(posedge i_clk) begin
        if ((ray_ch.valid && ray_ch.ready) || (hit_ch.valid && hit_ch.ready)
            || (cfg_ch.valid && cfg_ch.ready)
            || (hit_queue.size() == 0 && !ray_ch.valid && !cfg_ch.valid))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= STALL_LIMIT) begin
            $display("timeout with %0d hits outstanding", hit_queue.size());
            $display("*** FAILED ***");
            $finish;
        end
    end

    // ------------------------------------------------------------------------
    // tests
    // ------------------------------------------------------------------------
    task automatic test_directed();
        // miss, zero velocity, tangent, head-on through center, crossing, start at center
        send_ray(q16(100000), 0, 0, 0, q16(1), 0);
        send_ray(0, 0, 0, 0, 0, 0);
        send_ray(q16(-10000), q16(6371), 0, q16(1), 0, 0);
        send_ray(q16(-10000), 0, 0, q16(1), 0, 0);
        send_ray(q16(-10000), q16(3), q16(-2), q16(2), 0, q16(-1));
        send_ray(0, 0, 0, 0, 0, q16(1));
        // field extremes and saturation
        send_ray(COORD_MAX, COORD_MAX, COORD_MAX, COORD_MIN, COORD_MIN, COORD_MIN);
        send_ray(COORD_MIN, COORD_MIN, COORD_MIN, COORD_MAX, COORD_MAX, COORD_MAX);
        send_ray(0, 0, 0, 1, 0, 0);
        send_ray(0, 0, 0, -1, -1, -1);
        send_ray(COORD_MIN, 0, 0, 1, 0, 0);
        send_ray(q16(6371), 0, 0, 0, 1, 0);
        send_ray(0, COORD_MAX, 0, 0, COORD_MIN, 0);
        send_ray(0, 0, COORD_MIN, 0, 0, COORD_MAX);
    endtask

    task automatic test_radius_extremes();
        write_radius('0);
        send_ray(q16(-5), 0, 0, q16(1), 0, 0);
        send_ray(q16(-5), q16(1), 0, q16(1), 0, 0);
        send_ray(0, 0, 0, q16(1), 0, 0);
        write_radius('1);
        send_ray(0, 0, 0, q16(1), q16(1), q16(1));
        send_ray(COORD_MAX, COORD_MIN, 0, 1, 1, 1);
        send_ray(0, 0, 0, 1, 0, 0);
        write_radius(t_rad'(1));
        send_ray(-1, 0, 0, 1, 0, 0);
        send_ray(-2, 1, 0, 1, 0, 0);
    endtask

    // mostly rays aimed near the sphere so both roots get exercised
    task automatic test_random(int n, t_rad r);
        t_coord o [3];
        t_coord v [3];
        write_radius(r);
        for (int i = 0; i < n; i++) begin
            for (int k = 0; k < 3; k++) begin
                o[k] = rand_coord();
                v[k] = rand_coord();
            end
            if ($urandom_range(0, 3) != 0) begin
                // aim roughly from the origin point back at the center
                for (int k = 0; k < 3; k++)
                    v[k] = t_coord'(-(o[k] >>> $urandom_range(4, 20)))
                           + t_coord'($urandom_range(0, 255));
            end
            send_ray(o[0], o[1], o[2], v[0], v[1], v[2]);
        end
    endtask

    initial begin
        error_count = 0;
        rays_sent   = 0;
        hits_seen   = 0;
        hit_tally   = '{0, 0, 0};
        idle_cycles = 0;
        calm_mode   = 1'b0;
        radius_q    = RAD_RESET;
        i_rst_n     = 1'b0;
        ray_ch.valid      = 1'b0;
        ray_ch.origin_x   = '0;
        ray_ch.origin_y   = '0;
        ray_ch.origin_z   = '0;
        ray_ch.velocity_x = '0;
        ray_ch.velocity_y = '0;
        ray_ch.velocity_z = '0;
        cfg_ch.valid         = 1'b0;
        cfg_ch.sphere_radius = '0;
        hit_ch.ready         = 1'b0;
        repeat (11) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        test_directed();
        test_radius_extremes();
        test_random(400, RAD_RESET);
        test_random(300, t_rad'($urandom));
        test_random(200, t_rad'(q16(5)));
        // last part runs with no idling on either side
        calm_mode = 1'b1;
        test_random(200, RAD_RESET);

        wait_drained();
        repeat (DRAIN_CYCLES) @(negedge i_clk);
        $display("rays %0d, hits checked %0d (miss %0d, tangent %0d, crossing %0d)",
                 rays_sent, hits_seen, hit_tally[0], hit_tally[1], hit_tally[2]);
        $display("radius settings: reset, zero, full scale, one lsb, random, 5.0");
        if (error_count == 0 && hit_queue.size() == 0) begin
            $display("*** PASSED ***");
        end else begin
            $display("*** FAILED ***");
        end
        $finish;
    end

endmodule

`default_nettype wire
